// ----- rtl/swsl_pkg.sv -----
// Shared types and constants of the slope leak detector.
package swsl_pkg;

  localparam int SLOPE_W   = 41;
  localparam int Q_FRAC    = 8;
  localparam int DIV_SHIFT = SLOPE_W - Q_FRAC;
  localparam int DCNT_W    = $clog2(SLOPE_W + 1);
  localparam int MIN_WIN   = 3;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic CFG_TREND_WINDOW = 1'b0;
  localparam logic CFG_MEM_LIMIT    = 1'b1;

  typedef enum logic [1:0] {
    ALERT_NONE   = 2'd0,
    ALERT_MEM    = 2'd1,
    ALERT_HANDLE = 2'd2
  } alert_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_CHK,
    S_WALK,
    S_PROD,
    S_NUMER,
    S_CMP,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic   in_ready;
    logic   load;
    logic   clear;
    logic   upd;
    logic   walk_init;
    logic   walk_sel_mem;
    logic   walk;
    logic   prod;
    logic   numer;
    logic   div_init;
    logic   div_step;
    logic   kind_ld;
    alert_t kind;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_clear;
    logic in_ok;
    logic go;
    logic walk_done;
    logic hit;
    logic sel_mem;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/swsl_if.sv -----
// Request and result channel interfaces.
interface swsl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  channel;
  logic [31:0] mem_kb;
  logic [15:0] handle_count;
  modport source (output valid, action, channel, mem_kb, handle_count, input ready);
  modport sink   (input valid, action, channel, mem_kb, handle_count, output ready);
endinterface

interface swsl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         alert_kind;
  logic signed [40:0] slope_q8;
  modport source (output valid, alert_kind, slope_q8, input ready);
  modport sink   (input valid, alert_kind, slope_q8, output ready);
endinterface

// ----- rtl/swsl_ctrl.sv -----
// Sequencer for update, window walks, compare and divide.
module swsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  swsl_pkg::status_t status,
  output swsl_pkg::cmd_t    cmd
);

  swsl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swsl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = swsl_pkg::ALERT_NONE;
    state_nxt = state_r;
    case (state_r)
      swsl_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          if (status.in_clear) begin
            cmd.clear = 1'b1;
          end else if (status.in_ok) begin
            cmd.load  = 1'b1;
            state_nxt = swsl_pkg::S_UPD;
          end
        end
      end
      swsl_pkg::S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = swsl_pkg::S_CHK;
      end
      swsl_pkg::S_CHK: begin
        if (status.go) begin
          cmd.walk_init    = 1'b1;
          cmd.walk_sel_mem = 1'b1;
          state_nxt        = swsl_pkg::S_WALK;
        end else begin
          cmd.kind_ld = 1'b1;
          state_nxt   = swsl_pkg::S_EMIT;
        end
      end
      swsl_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = swsl_pkg::S_PROD;
        end
      end
      swsl_pkg::S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = swsl_pkg::S_NUMER;
      end
      swsl_pkg::S_NUMER: begin
        cmd.numer = 1'b1;
        state_nxt = swsl_pkg::S_CMP;
      end
      swsl_pkg::S_CMP: begin
        if (status.hit) begin
          cmd.div_init = 1'b1;
          cmd.kind_ld  = 1'b1;
          cmd.kind     = status.sel_mem ? swsl_pkg::ALERT_MEM : swsl_pkg::ALERT_HANDLE;
          state_nxt    = swsl_pkg::S_DIV;
        end else if (status.sel_mem) begin
          // memory trend quiet, try handles
          cmd.walk_init = 1'b1;
          state_nxt     = swsl_pkg::S_WALK;
        end else begin
          cmd.kind_ld = 1'b1;
          state_nxt   = swsl_pkg::S_EMIT;
        end
      end
      swsl_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = swsl_pkg::S_EMIT;
        end
      end
      swsl_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = swsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swsl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/swsl_dp.sv -----
// Datapath: history rings, sums, products, compare and restoring divider.
module swsl_dp #(
  parameter int CHANNELS   = 16,
  parameter int WINDOW_MAX = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_action,
  input  logic [3:0]               in_channel,
  input  logic [31:0]              in_mem_kb,
  input  logic [15:0]              in_handle_count,
  output logic                     out_valid,
  output logic [1:0]               out_alert_kind,
  output logic signed [40:0]       out_slope_q8,
  input  logic                     out_ready,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [31:0]              cfg_data,
  input  swsl_pkg::cmd_t           cmd,
  output swsl_pkg::status_t        status
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = $clog2(WINDOW_MAX);
  localparam int LW   = $clog2(WINDOW_MAX + 1);
  localparam int MD   = CHANNELS * WINDOW_MAX;
  localparam int AW   = $clog2(MD);
  localparam int SYW  = 32 + LW;
  localparam int SXYW = 32 + 2 * LW;
  localparam int N12W = LW + 4;
  localparam int SXW  = 2 * LW + 3;
  localparam int PRW  = N12W + SXYW;
  localparam int NW   = PRW + 1;
  localparam int DW   = 4 * LW;
  localparam int LMW  = 32 + DW;
  localparam int CBW  = (PRW > LMW) ? PRW : LMW;
  localparam int SW   = swsl_pkg::SLOPE_W;

  // configuration
  logic [6:0]  trend_r;
  logic [31:0] limit_r;

  // per-channel ring pointers
  logic [LW-1:0] fill_r   [CHANNELS];
  logic [PW-1:0] oldest_r [CHANNELS];

  // history memory: {mem_kb, handle_count}
  logic [47:0] mem_r [MD];
  logic [47:0] rd_r;

  logic [CW-1:0]  ch_r;
  logic [AW-1:0]  base_r;
  logic [31:0]    mkb_r;
  logic [15:0]    hc_r;
  logic [LW-1:0]  n_r;
  logic           go_r;
  logic           sel_mem_r;
  logic [LW-1:0]  k_r, kd_r;
  logic [PW-1:0]  pos_r;
  logic           vld_r;
  logic [SYW-1:0]  sy_r;
  logic [SXYW-1:0] sxy_r;
  logic [N12W-1:0] n12_r;
  logic [SXW-1:0]  sx12_r;
  logic [2*LW-1:0] n2_r;
  logic [PRW-1:0]  p1_r, p2_r;
  logic [DW-1:0]   d_r;
  logic signed [NW-1:0] num12_r;
  logic [LMW-1:0]  lim_r;
  logic [DW-1:0]   rem_r;
  logic [SW-1:0]   xs_r;
  logic [SW-1:0]   q_r;
  logic [swsl_pkg::DCNT_W-1:0] cnt_r;
  swsl_pkg::alert_t kind_r;
  logic            out_valid_r;
  logic [1:0]      out_kind_r;
  logic [SW-1:0]   out_slope_r;

  logic            accept;
  logic [LW-1:0]   w_eff;
  logic [LW-1:0]   f_cur, f1, f2, drop;
  logic [PW-1:0]   o_cur, o1, o2, pos_w;
  logic [PW:0]     sum_a, sum_b;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     y;
  logic            pos_num;
  logic [PRW-1:0]  mag;
  logic            hit_mem, hit_hnd;
  logic [DW:0]     trial;
  logic            ge;

  assign accept = in_valid && cmd.in_ready;

  always_comb begin
    if (trend_r == 7'd0) begin
      w_eff = LW'(1);
    end else if (32'(trend_r) > 32'(WINDOW_MAX)) begin
      w_eff = LW'(WINDOW_MAX);
    end else begin
      w_eff = LW'(trend_r);
    end
  end

  // ring update: append, then trim down to the window
  always_comb begin
    f_cur = fill_r[ch_r];
    o_cur = oldest_r[ch_r];
    sum_a = (PW+1)'(o_cur) + (PW+1)'(f_cur);
    if (32'(f_cur) < 32'(WINDOW_MAX)) begin
      pos_w = (sum_a >= (PW+1)'(WINDOW_MAX)) ? PW'(sum_a - (PW+1)'(WINDOW_MAX)) : PW'(sum_a);
      f1    = f_cur + LW'(1);
      o1    = o_cur;
    end else begin
      pos_w = o_cur;
      f1    = f_cur;
      o1    = (32'(o_cur) == WINDOW_MAX - 1) ? '0 : o_cur + PW'(1);
    end
    drop  = f1 - w_eff;
    sum_b = (PW+1)'(o1) + (PW+1)'(drop);
    if (f1 > w_eff) begin
      o2 = (sum_b >= (PW+1)'(WINDOW_MAX)) ? PW'(sum_b - (PW+1)'(WINDOW_MAX)) : PW'(sum_b);
      f2 = w_eff;
    end else begin
      o2 = o1;
      f2 = f1;
    end
  end

  assign rd_addr = base_r + AW'(pos_r);
  assign y       = sel_mem_r ? rd_r[47:16] : {16'd0, rd_r[15:0]};

  assign pos_num = !num12_r[NW-1] && (num12_r != '0);
  assign mag     = num12_r[PRW-1:0];
  assign hit_mem = pos_num && (CBW'(mag) > CBW'(lim_r));
  assign hit_hnd = pos_num && (CBW'(mag) > CBW'(d_r));

  assign trial = {rem_r, xs_r[SW-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trend_r     <= 7'd10;
      limit_r     <= 32'd1024;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        fill_r[c]   <= '0;
        oldest_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swsl_pkg::CFG_TREND_WINDOW: trend_r <= cfg_data[6:0];
          swsl_pkg::CFG_MEM_LIMIT:    limit_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        for (int c = 0; c < CHANNELS; c++) begin
          fill_r[c]   <= '0;
          oldest_r[c] <= '0;
        end
      end else if (cmd.upd) begin
        fill_r[ch_r]   <= f2;
        oldest_r[ch_r] <= o2;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem_r[rd_addr];
    if (cmd.upd) begin
      mem_r[base_r + AW'(pos_w)] <= {mkb_r, hc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.load) begin
      ch_r   <= CW'(in_channel);
      base_r <= AW'(32'(CW'(in_channel)) * WINDOW_MAX);
      mkb_r  <= in_mem_kb;
      hc_r   <= in_handle_count;
    end
    if (cmd.upd) begin
      n_r  <= f2;
      go_r <= (f2 >= w_eff) && (32'(w_eff) >= swsl_pkg::MIN_WIN);
    end
    if (cmd.walk_init) begin
      sel_mem_r <= cmd.walk_sel_mem;
      k_r       <= '0;
      pos_r     <= oldest_r[ch_r];
      vld_r     <= 1'b0;
      sy_r      <= '0;
      sxy_r     <= '0;
      n12_r     <= N12W'(n_r) * N12W'(12);
      sx12_r    <= SXW'(n_r) * SXW'(n_r - LW'(1)) * SXW'(6);
      n2_r      <= (2*LW)'(n_r) * (2*LW)'(n_r);
    end else if (cmd.walk) begin
      if (k_r != n_r) begin
        vld_r <= 1'b1;
        kd_r  <= k_r;
        k_r   <= k_r + LW'(1);
        pos_r <= (32'(pos_r) == WINDOW_MAX - 1) ? '0 : pos_r + PW'(1);
      end else begin
        vld_r <= 1'b0;
      end
      if (vld_r) begin
        sy_r  <= sy_r + SYW'(y);
        sxy_r <= sxy_r + SXYW'(kd_r) * SXYW'(y);
      end
    end
    if (cmd.prod) begin
      // scaled by 12 so the slope denominator is n^2 (n^2 - 1)
      p1_r <= PRW'(n12_r) * PRW'(sxy_r);
      p2_r <= PRW'(sx12_r) * PRW'(sy_r);
      d_r  <= DW'(n2_r) * DW'(n2_r - (2*LW)'(1));
    end
    if (cmd.numer) begin
      num12_r <= $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
      lim_r   <= LMW'(limit_r) * LMW'(d_r);
    end
    if (cmd.div_init) begin
      rem_r <= DW'(mag >> swsl_pkg::DIV_SHIFT);
      xs_r  <= {mag[swsl_pkg::DIV_SHIFT-1:0], swsl_pkg::Q_FRAC'(0)};
      q_r   <= '0;
      cnt_r <= swsl_pkg::DCNT_W'(SW);
    end else if (cmd.div_step && cnt_r != '0) begin
      rem_r <= ge ? DW'(trial - {1'b0, d_r}) : DW'(trial);
      xs_r  <= xs_r << 1;
      q_r   <= {q_r[SW-2:0], ge};
      cnt_r <= cnt_r - swsl_pkg::DCNT_W'(1);
    end
    if (cmd.kind_ld) begin
      kind_r <= cmd.kind;
    end
    if (cmd.emit) begin
      out_kind_r  <= kind_r;
      out_slope_r <= (kind_r == swsl_pkg::ALERT_NONE) ? '0 : q_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alert_kind = out_kind_r;
  assign out_slope_q8   = $signed(out_slope_r);

  always_comb begin
    status           = '0;
    status.in_valid  = in_valid;
    status.in_clear  = (in_action == swsl_pkg::ACT_CLEAR);
    status.in_ok     = (32'(in_channel) < 32'(CHANNELS));
    status.go        = go_r;
    status.walk_done = (k_r == n_r) && !vld_r;
    status.hit       = sel_mem_r ? hit_mem : hit_hnd;
    status.sel_mem   = sel_mem_r;
    status.div_done  = (cnt_r == '0);
    status.out_free  = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  a_trim_to_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (n_r <= w_eff))
    else $error("history longer than window after update");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> (rem_r < d_r))
    else $error("slope quotient overflows result width");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && (kind_r == swsl_pkg::ALERT_NONE) |=> (out_slope_r == '0))
    else $error("no-alert result carries a slope");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_slope_r))
    else $error("pending result lost");
`endif

endmodule

// ----- rtl/sliding_window_slope_leak_detector.sv -----
// Top level of the least-squares slope leak detector.
//
//  port     dir  handshake           payload
//  in_ch    in   valid/ready         action, channel, mem_kb, handle_count
//  out_ch   out  valid/ready         alert_kind, slope_q8
//  cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One request at a time. A sample that fills a window of n walks the memory trend, forms the
// products and numerator and compares; a memory alert then runs the divide before the result. A
// quiet memory trend also walks the handles, and no alert skips the 41-step divide. Each window
// walk reads through the single read port of the history memory.
// A sample that does not fill the window goes from update to the result; a clear acts on acceptance.
// Reset is synchronous and empties all channel histories at once.
// A waiting result does not block acceptance of the next request.
module sliding_window_slope_leak_detector #(
  parameter int CHANNELS   = 16,
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  swsl_in_if.sink     in_ch,
  swsl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  swsl_pkg::cmd_t    cmd;
  swsl_pkg::status_t status;

  assign in_ch.ready = cmd.in_ready;

  swsl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  swsl_dp #(
    .CHANNELS   (CHANNELS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_action       (in_ch.action),
    .in_channel      (in_ch.channel),
    .in_mem_kb       (in_ch.mem_kb),
    .in_handle_count (in_ch.handle_count),
    .out_valid       (out_ch.valid),
    .out_alert_kind  (out_ch.alert_kind),
    .out_slope_q8    (out_ch.slope_q8),
    .out_ready       (out_ch.ready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// ----- test/tb_sliding_window_slope_leak_detector.sv -----
// Testbench for the slope leak detector: directed and random requests against a predictor.
module tb_sliding_window_slope_leak_detector;

  localparam int NCH  = 16;
  localparam int WMAX = 64;

  typedef struct {
    swsl_pkg::alert_t   kind;
    logic signed [40:0] slope;
  } alert_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = swsl_pkg::CFG_TREND_WINDOW;
  logic [31:0] cfg_data = '0;

  swsl_in_if  in_if();
  swsl_out_if out_if();

  sliding_window_slope_leak_detector uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // trend history mirror
  logic [31:0] mem_hist [NCH][WMAX];
  logic [15:0] hc_hist [NCH][WMAX];
  int unsigned held [NCH];
  int unsigned head [NCH];
  logic [6:0]  win_reg;
  logic [31:0] limit_reg;

  alert_rec_t expected_alerts[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // per-channel ramp generator for well-formed trends
  logic [31:0] ramp_mem [NCH];
  logic [31:0] ramp_mem_step [NCH];
  logic [15:0] ramp_hc [NCH];
  logic [15:0] ramp_hc_step [NCH];

  function automatic longint trend_numerator(int unsigned ch, int unsigned n, bit is_mem);
    longint unsigned sy, sxy, sx, y;
    int unsigned pos;
    sy = 0;
    sxy = 0;
    for (int unsigned k = 0; k < n; k++) begin
      pos = (head[ch] + k) % WMAX;
      y = is_mem ? longint'(mem_hist[ch][pos]) : longint'(hc_hist[ch][pos]);
      sy += y;
      sxy += longint'(k) * y;
    end
    sx = longint'(n) * longint'(n - 1) / 2;
    return longint'(longint'(n) * sxy) - longint'(sx * sy);
  endfunction

  function automatic longint unsigned to_q8(longint unsigned num, longint unsigned den);
    return (num / den) * 256 + ((num % den) * 256) / den;
  endfunction

  function automatic void predict_trend(logic act, logic [3:0] ch, logic [31:0] m,
                                        logic [15:0] h);
    int unsigned w, pos;
    longint unsigned nn, den, q;
    longint mn, hn;
    alert_rec_t rec;
    if (act == swsl_pkg::ACT_CLEAR) begin
      for (int c = 0; c < NCH; c++) begin
        held[c] = 0;
        head[c] = 0;
      end
      return;
    end
    if (held[ch] < WMAX) begin
      pos = (head[ch] + held[ch]) % WMAX;
      held[ch]++;
    end else begin
      pos = head[ch];
      head[ch] = (head[ch] + 1) % WMAX;
    end
    mem_hist[ch][pos] = m;
    hc_hist[ch][pos] = h;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WMAX) w = WMAX;
    if (held[ch] > w) begin
      head[ch] = (head[ch] + held[ch] - w) % WMAX;
      held[ch] = w;
    end
    rec.kind = swsl_pkg::ALERT_NONE;
    q = 0;
    if (held[ch] >= w && w >= swsl_pkg::MIN_WIN) begin
      nn = w;
      den = nn * nn * (nn * nn - 1) / 12;
      mn = trend_numerator(ch, w, 1'b1);
      if (mn > 0 && longint'(mn) > longint'(longint'(limit_reg) * den)) begin
        rec.kind = swsl_pkg::ALERT_MEM;
        q = to_q8(mn, den);
      end else begin
        hn = trend_numerator(ch, w, 1'b0);
        if (hn > 0 && longint'(hn) > longint'(den)) begin
          rec.kind = swsl_pkg::ALERT_HANDLE;
          q = to_q8(hn, den);
        end
      end
    end
    rec.slope = q[40:0];
    expected_alerts.insert(expected_alerts.size(), rec);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(logic act, logic [3:0] ch, logic [31:0] m, logic [15:0] h);
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.channel <= ch;
    in_if.mem_kb <= m;
    in_if.handle_count <= h;
    do @(posedge clk); while (!in_if.ready);
    predict_trend(act, ch, m, h);
    @(negedge clk);
  endtask

  task automatic sample(logic [3:0] ch, logic [31:0] m, logic [15:0] h);
    send_req(swsl_pkg::ACT_SAMPLE, ch, m, h);
  endtask

  // block idle: valid low, all results in, clear has had time to finish
  task automatic drain;
    in_if.valid <= 1'b0;
    wait (expected_alerts.size() == 0);
    repeat (300) @(negedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == swsl_pkg::CFG_TREND_WINDOW) win_reg = val[6:0];
    else limit_reg = val;
  endtask

  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    alert_rec_t exp_rec;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_alerts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d slope %0d", out_if.alert_kind,
                   out_if.slope_q8);
      end else begin
        exp_rec = expected_alerts[0];
        expected_alerts.delete(0);
        if (out_if.alert_kind !== exp_rec.kind || out_if.slope_q8 !== exp_rec.slope) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d slope %0d, got kind %0d slope %0d",
                     exp_rec.kind, exp_rec.slope, out_if.alert_kind, out_if.slope_q8);
        end
      end
    end
  end

  task automatic test_default_mem_trend;
    for (int i = 0; i < 10; i++) sample(4'd0, 32'd5000 + 2000 * i, 16'd7);
  endtask

  task automatic test_handle_trend_extremes;
    cfg_write(swsl_pkg::CFG_TREND_WINDOW, 32'd3);
    sample(4'd15, 32'hFFFF_FFFF, 16'h0000);
    sample(4'd15, 32'h8000_0000, 16'h8000);
    sample(4'd15, 32'h0000_0000, 16'hFFFF);
  endtask

  task automatic test_clear;
    send_req(swsl_pkg::ACT_CLEAR, 4'd3, 32'hFFFF_FFFF, 16'hFFFF);
    sample(4'd15, 32'd10, 16'd10);
  endtask

  task automatic test_window_zero;
    cfg_write(swsl_pkg::CFG_TREND_WINDOW, 32'd0);
    sample(4'd1, 32'd0, 16'd0);
    sample(4'd1, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_limit_extremes;
    cfg_write(swsl_pkg::CFG_TREND_WINDOW, 32'd3);
    cfg_write(swsl_pkg::CFG_MEM_LIMIT, 32'd0);
    for (int i = 0; i < 3; i++) sample(4'd2, 32'(i), 16'd1);
    cfg_write(swsl_pkg::CFG_MEM_LIMIT, 32'hFFFF_FFFF);
    sample(4'd2, 32'd0, 16'd1);
    sample(4'd2, 32'h7FFF_FFFF, 16'd1);
    sample(4'd2, 32'hFFFF_FFFF, 16'd1);
  endtask

  task automatic test_window_shrink;
    cfg_write(swsl_pkg::CFG_MEM_LIMIT, 32'd1024);
    cfg_write(swsl_pkg::CFG_TREND_WINDOW, 32'd4);
    sample(4'd0, 32'd30000, 16'd7);
  endtask

  task automatic test_random(int n_items, int hot, logic [6:0] w, logic [31:0] lim);
    int r;
    logic [3:0] ch;
    cfg_write(swsl_pkg::CFG_TREND_WINDOW, 32'(w));
    cfg_write(swsl_pkg::CFG_MEM_LIMIT, lim);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_req(swsl_pkg::ACT_CLEAR, 4'($urandom), $urandom, 16'($urandom));
      end else if (r < 15) begin
        sample(4'($urandom), $urandom, 16'($urandom));
      end else begin
        ch = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(hot));
        if ($urandom_range(19) == 0) begin
          ramp_mem[ch] = $urandom;
          ramp_hc[ch] = 16'($urandom);
          case ($urandom_range(3))
            0: ramp_mem_step[ch] = 0;
            1: ramp_mem_step[ch] = $urandom_range(2048);
            2: ramp_mem_step[ch] = lim + $urandom_range(2) - 1;
            default: ramp_mem_step[ch] = $urandom;
          endcase
          ramp_hc_step[ch] = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        end
        ramp_mem[ch] += ramp_mem_step[ch] + $urandom_range(3);
        ramp_hc[ch] += ramp_hc_step[ch] + 16'($urandom_range(3) == 0);
        sample(ch, ramp_mem[ch], ramp_hc[ch]);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.action = swsl_pkg::ACT_SAMPLE;
    in_if.channel = '0;
    in_if.mem_kb = '0;
    in_if.handle_count = '0;
    out_if.ready = 1'b0;
    win_reg = 7'd10;
    limit_reg = 32'd1024;
    for (int c = 0; c < NCH; c++) begin
      held[c] = 0;
      head[c] = 0;
      ramp_mem[c] = $urandom;
      ramp_mem_step[c] = $urandom_range(4096);
      ramp_hc[c] = 16'($urandom);
      ramp_hc_step[c] = 16'($urandom_range(3));
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 31;
    recv_idle = 73;
    test_default_mem_trend();
    test_handle_trend_extremes();
    test_clear();
    test_window_zero();
    test_limit_extremes();
    test_window_shrink();
    test_random(225, 1, 7'd64, 32'd1024);
    test_random(225, 3, 7'd10, 32'd0);
    send_idle = 73;
    recv_idle = 31;
    test_random(225, 3, 7'd127, 32'hFFFF_FFFF);
    test_random(225, 7, 7'd3, 32'($urandom_range(4096)));
    send_idle = 0;
    recv_idle = 0;
    test_random(225, 1, 7'd64, 32'd100);
    test_random(200, 15, 7'($urandom_range(127)), $urandom);

    drain();
    if (mismatches == 0 && expected_alerts.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #240_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
